// File: rtl/core/branch_target_map_checker_top_macros.svh
// Assertion macros used by the checker RTL (btmc_ctrl).
`ifndef BRANCH_TARGET_MAP_CHECKER_TOP_MACROS_SVH
`define BRANCH_TARGET_MAP_CHECKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising clock edge outside reset.
`define BTM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define BTM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BTM_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/btmc_pkg.sv
package btmc_pkg;

	// Region and map geometry
	localparam int REGION_BYTES     = 65536;
	localparam int TRAMPOLINE_ALIGN = 32;
	localparam int ROW_BITS         = 32;
	localparam int ROW_SH           = $clog2(ROW_BITS);
	localparam int ROWS             = (REGION_BYTES + ROW_BITS - 1) / ROW_BITS;
	localparam int OFF_W            = $clog2(REGION_BYTES);
	localparam int ROW_W            = OFF_W - ROW_SH;
	localparam int CNT_W            = OFF_W + 1;
	localparam int WROW_W           = CNT_W - ROW_SH;
	localparam int POP_W            = $clog2(ROW_BITS + 1);

	// Port widths
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 168;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BASE       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CODE_LIMIT      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_32        = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TRAMPOLINE_SPAN = CFG_IDX_W'(3);

	// Register reset values
	localparam logic [31:0] CODE_BASE_RST       = 32'd0;
	localparam logic [31:0] CODE_LIMIT_RST      = 32'd65536;
	localparam logic        ALIGN_32_RST        = 1'b0;
	localparam logic [31:0] TRAMPOLINE_SPAN_RST = 32'd131072;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_TARGET = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_FINISH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_ACCEPTED     = 2'd0,
		STS_OUT_OF_RANGE = 2'd1,
		STS_DUPLICATE    = 2'd2,
		STS_TRAMPOLINE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic op_write;
		logic walk_init;
		logic walk_step;
		logic clear_step;
		logic load_result;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic op_is_walk;
		logic walk_done;
		logic walk_busy;
	} dp_sts_t;

endpackage

// File: rtl/core/branch_target_map_checker_top.sv
// Record events (start, target, clear): the beat is accepted and its map row read in ST_IDLE,
// the row is written in ST_EXEC and the result is loaded in ST_RESULT. Finish walk: one 32-byte map row per cycle.
// A new record event is taken only after the result of the last one is loaded.
// Reset (arst_n low, asynchronous) clears counters, flags and registers; a clearing
// pass over all 2048 rows then zeroes both maps, with s_tready low and config taken.
module branch_target_map_checker_top
	import btmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Event stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // address[31:0], branch_target[63:32]
	input  logic [IN_USER_W-1:0]  s_tuser,  // op[1:0]
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[1:0], finished[2], failed[3], instr_count[35:4], checked_count[67:36],
	// bad_target_count[99:68], bad_align_count[131:100], internal_count[163:132]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Registers are plain flops; take every write beat at once.
	assign cfg_ready = 1'b1;

	// Sequence the clearing pass, the event execution and the walk.
	btmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the maps, the totals and the result register. The result register
	// parts the two sides: a new beat is taken while the last result waits.
	btmc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_data  (m_tdata)
	);

endmodule

// File: rtl/core/btmc_datapath.sv
module btmc_datapath
	import btmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [IN_USER_W-1:0]  in_user,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [OUT_DATA_W-1:0] res_data
);

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [POP_W-1:0] n);
		logic [32:0] s;
		s = {1'b0, a} + 33'(n);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Configuration registers
	logic [31:0] code_base_q, code_limit_q, tramp_span_q;
	logic        align_32_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_base_q  <= CODE_BASE_RST;
			code_limit_q <= CODE_LIMIT_RST;
			align_32_q   <= ALIGN_32_RST;
			tramp_span_q <= TRAMPOLINE_SPAN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CODE_BASE:       code_base_q  <= cfg_data;
				REG_CODE_LIMIT:      code_limit_q <= cfg_data;
				REG_ALIGN_32:        align_32_q   <= cfg_data[0];
				REG_TRAMPOLINE_SPAN: tramp_span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify the incoming beat
	op_t         in_op;
	logic [31:0] in_addr, in_tgt, in_a, in_diff;
	logic        in_range, in_tramp;

	always_comb begin
		in_op    = op_t'(in_user[1:0]);
		in_addr  = in_data[31:0];
		in_tgt   = in_data[63:32];
		in_a     = (in_op == OP_TARGET) ? in_tgt : in_addr;
		in_diff  = in_a - code_base_q;
		in_range = (in_a >= code_base_q) && (in_a < code_limit_q) &&
			(in_diff < 32'(REGION_BYTES));
		in_tramp = (in_tgt < code_base_q) && (in_tgt < code_limit_q) &&
			((code_base_q - in_tgt) <= tramp_span_q) &&
			((in_tgt % 32'(TRAMPOLINE_ALIGN)) == 32'd0);
	end

	op_t               op_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_SH-1:0] bidx_q;
	logic              in_range_q, tramp_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= in_op;
			row_q      <= in_diff[OFF_W-1:ROW_SH];
			bidx_q     <= in_diff[ROW_SH-1:0];
			in_range_q <= in_range;
			tramp_q    <= in_tramp;
		end
	end

	// Walk control
	logic [CNT_W-1:0]  len_q;
	logic [WROW_W-1:0] walk_row_q;
	logic              issue_done;
	logic [32:0]       span_len;

	assign span_len   = {1'b0, code_limit_q} - {1'b0, code_base_q};
	assign issue_done = ((CNT_W'(walk_row_q) << ROW_SH) >= len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			walk_row_q <= '0;
		end else if (cmd.walk_init) begin
			walk_row_q <= '0;
			if (span_len[32] || span_len == 33'd0)
				len_q <= '0;
			else if (span_len > 33'(REGION_BYTES))
				len_q <= CNT_W'(REGION_BYTES);
			else
				len_q <= span_len[CNT_W-1:0];
		end else if (cmd.walk_step && !issue_done) begin
			walk_row_q <= walk_row_q + WROW_W'(1);
		end
	end

	// Map memories: one read and one write port each
	logic [ROW_BITS-1:0] start_mem [ROWS];
	logic [ROW_BITS-1:0] tgt_mem   [ROWS];
	logic [ROW_BITS-1:0] start_rd_q, tgt_rd_q;
	logic [ROW_W-1:0]    rd_row, wr_row, clr_row_q;
	logic                start_we, tgt_we, dup;
	logic [ROW_BITS-1:0] bmask, start_wdata, tgt_wdata;

	assign rd_row = cmd.accept ? in_diff[OFF_W-1:ROW_SH] : walk_row_q[ROW_W-1:0];

	always_ff @(posedge clk) begin
		start_rd_q <= start_mem[rd_row];
		tgt_rd_q   <= tgt_mem[rd_row];
	end

	always_comb begin
		bmask       = ROW_BITS'(1) << bidx_q;
		dup         = |(start_rd_q & bmask);
		wr_row      = cmd.clear_step ? clr_row_q : row_q;
		start_we    = cmd.clear_step ||
			(cmd.op_write && in_range_q &&
			 ((op_q == OP_START && !dup) || op_q == OP_CLEAR));
		tgt_we      = cmd.clear_step || (cmd.op_write && in_range_q && op_q == OP_TARGET);
		start_wdata = cmd.clear_step ? '0 :
			(op_q == OP_CLEAR) ? (start_rd_q & ~bmask) : (start_rd_q | bmask);
		tgt_wdata   = cmd.clear_step ? '0 : (tgt_rd_q | bmask);
	end

	always_ff @(posedge clk) begin
		if (start_we)
			start_mem[wr_row] <= start_wdata;
		if (tgt_we)
			tgt_mem[wr_row] <= tgt_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_row_q <= '0;
		else if (cmd.clear_step)
			clr_row_q <= clr_row_q + ROW_W'(1);
	end

	// Walk pipeline: row read, mask and count, accumulate
	logic                v_s1, v_s2;
	logic [WROW_W-1:0]   row_s1;
	logic [POP_W-1:0]    chk_cnt_s2, bad_cnt_s2, blk_cnt_s2;
	logic [CNT_W-1:0]    rem;
	logic [ROW_BITS-1:0] lim_mask, blk_pat, tgt_v;

	always_comb begin
		rem      = len_q - (CNT_W'(row_s1) << ROW_SH);
		lim_mask = (rem >= CNT_W'(ROW_BITS)) ? '1 :
			~({ROW_BITS{1'b1}} << rem[ROW_SH-1:0]);
		blk_pat  = ROW_BITS'(1) | (align_32_q ? '0 : (ROW_BITS'(1) << 16));
		tgt_v    = tgt_rd_q & lim_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk_step && !issue_done;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1     <= walk_row_q;
		chk_cnt_s2 <= POP_W'($countones(tgt_v));
		bad_cnt_s2 <= POP_W'($countones(tgt_v & ~start_rd_q));
		blk_cnt_s2 <= POP_W'($countones(lim_mask & blk_pat & ~start_rd_q));
	end

	// Totals and sticky failure
	logic [31:0] instr_q, checked_q, bad_tgt_q, bad_align_q, internal_q;
	logic        fail_q;
	status_t     status_q;
	logic [POP_W-1:0] one;

	assign one = POP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_q     <= '0;
			checked_q   <= '0;
			bad_tgt_q   <= '0;
			bad_align_q <= '0;
			internal_q  <= '0;
			fail_q      <= 1'b0;
			status_q    <= STS_ACCEPTED;
		end else if (cmd.op_write) begin
			status_q <= STS_ACCEPTED;
			if (!in_range_q && !(op_q == OP_TARGET && tramp_q)) begin
				bad_tgt_q <= sat_add(bad_tgt_q, one);
				fail_q    <= 1'b1;
				status_q  <= STS_OUT_OF_RANGE;
			end else if (!in_range_q) begin
				status_q <= STS_TRAMPOLINE;
			end else if (op_q == OP_START && dup) begin
				internal_q <= sat_add(internal_q, one);
				fail_q     <= 1'b1;
				status_q   <= STS_DUPLICATE;
			end else if (op_q == OP_START) begin
				instr_q <= sat_add(instr_q, one);
			end
		end else if (cmd.walk_init) begin
			status_q <= STS_ACCEPTED;
			if ((code_base_q & (align_32_q ? 32'd31 : 32'd15)) != 32'd0) begin
				bad_align_q <= sat_add(bad_align_q, one);
				fail_q      <= 1'b1;
			end
		end else if (v_s2) begin
			checked_q   <= sat_add(checked_q, chk_cnt_s2);
			bad_tgt_q   <= sat_add(bad_tgt_q, bad_cnt_s2);
			bad_align_q <= sat_add(bad_align_q, blk_cnt_s2);
			if (bad_cnt_s2 != '0 || blk_cnt_s2 != '0)
				fail_q <= 1'b1;
		end
	end

	// Result register
	logic [OUT_DATA_W-1:0] res_q;

	always_ff @(posedge clk) begin
		if (cmd.load_result)
			res_q <= {4'd0, internal_q, bad_align_q, bad_tgt_q, checked_q, instr_q,
				fail_q, (op_q == OP_FINISH), status_q};
	end

	assign res_data = res_q;

	assign sts.clear_last = (clr_row_q == ROW_W'(ROWS - 1));
	assign sts.op_is_walk = (op_q == OP_FINISH);
	assign sts.walk_done  = issue_done;
	assign sts.walk_busy  = v_s1 || v_s2;

endmodule

// File: rtl/core/btmc_ctrl.sv
`include "branch_target_map_checker_top_macros.svh"

module btmc_ctrl
	import btmc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_EXEC;
			ST_EXEC:   state_d = sts.op_is_walk ? ST_WALK : ST_RESULT;
			ST_WALK:   if (sts.walk_done) state_d = ST_DRAIN;
			ST_DRAIN:  if (!sts.walk_busy) state_d = ST_RESULT;
			ST_RESULT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR:  cmd.clear_step = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_EXEC: begin
				cmd.walk_init = sts.op_is_walk;
				cmd.op_write  = !sts.op_is_walk;
			end
			ST_WALK:   cmd.walk_step = 1'b1;
			ST_RESULT: cmd.load_result = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_result)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	`BTM_ASSERT(a_accept_exec, clk, arst_n, cmd.accept |=> state_q == ST_EXEC, "accept did not start execution")
	`BTM_ASSERT(a_load_valid, clk, arst_n, cmd.load_result |=> out_valid_q, "loaded result not presented")
	`BTM_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.load_result && out_valid_q && !out_ready, "pending result overwritten")
	`BTM_ASSERT(a_walk_busy, clk, arst_n, sts.walk_busy |-> (state_q == ST_WALK || state_q == ST_DRAIN), "walk pipeline active outside walk")

endmodule
